>>> hdl/plt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the pixel log transform
// Register indexes, fixed-point widths and the elaboration-time log2 helper.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int CFG_W     = 14;   // width of every configuration register
    localparam int CFG_IDX_W = 2;
    localparam int LOG_PREC  = 30;   // fractional bits of the log mantissa
    localparam int ZW        = LOG_PREC + 1;
    localparam int KW        = 5;    // integer part of log2
    localparam int HUNDRED   = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURVE_A  = 2'd0,
        REG_OFFSET_B = 2'd1,
        REG_GAIN_C   = 2'd2
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] CURVE_A_RST  = 14'd100;
    localparam logic [CFG_W-1:0] OFFSET_B_RST = 14'd0;
    localparam logic [CFG_W-1:0] GAIN_C_RST   = 14'd100;

    // Fixed-point log2 with fb fractional bits, by repeated squaring.
    // Used only on constants at elaboration.
    function automatic logic [63:0] log2_fixed(input logic [63:0] n, input int fb);
        logic [63:0] k;
        logic [63:0] t;
        logic [63:0] z;
        logic [63:0] frac;
        int          i;
        k    = 64'd0;
        t    = n;
        frac = 64'd0;
        if (n == 64'd0) begin
            return 64'd0;
        end
        while (t > 64'd1) begin
            t = t >> 1;
            k = k + 64'd1;
        end
        if (k <= 64'(LOG_PREC)) begin
            z = n << (64'(LOG_PREC) - k);
        end else begin
            z = n >> (k - 64'(LOG_PREC));
        end
        for (i = 0; i < fb; i++) begin
            z    = (z * z) >> LOG_PREC;
            frac = frac << 1;
            if (z >= (64'd2 << LOG_PREC)) begin
                z    = z >> 1;
                frac = frac | 64'd1;
            end
        end
        return (k << fb) | frac;
    endfunction

endpackage
`default_nettype wire

>>> hdl/pixel_log_transform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_log_transform: logarithmic intensity transform of RGB pixels
//
// Slave stream s_*: one pixel a word, red in the lowest bits. Master stream
// m_*: the transformed pixel in the same layout. Each channel x becomes
// c*ln(1+a*x/M)/ln(1+a)*M + b, truncated and saturated to 0..M; with a = 0
// the straight line c*x + b is used. a, b and c sit in hundredths in three
// registers written through cfg_we/cfg_index/cfg_wdata; write them only
// while no pixel is in flight. Each pixel snapshots the registers on entry.
// Three lanes, one per channel, run side by side; the denominator log is
// shared. Throughput is one pixel per clock while the receiver takes each
// output word. The pipeline holds the squaring stages of the log units
// (one per fraction bit) and the quotient stages (one per bit).
// The whole pipeline advances together: when the receiver stalls a valid
// output word, every stage holds and s_tready drops. Reset (aresetn low,
// synchronous) empties the pipeline and restores a = 1.00, b = 0, c = 1.00.
// ----------------------------------------------------------------------------
module pixel_log_transform
    import plt_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // tdata: red_in, green_in, blue_in (lowest first)
    input  wire logic [((3*PIXEL_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // tdata: red_out, green_out, blue_out (lowest first)
    output logic [((3*PIXEL_BITS+7)/8)*8-1:0]          m_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic                                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                  cfg_index,
    input  wire logic [CFG_W-1:0]                      cfg_wdata
);

    localparam int P        = PIXEL_BITS;
    localparam int F        = FRAC_BITS;
    localparam int TW       = ((3 * P + 7) / 8) * 8;
    localparam int LW       = KW + F;
    localparam int DW       = CFG_W + 1;
    localparam int LANE_LAT = 2 * F + 9;
    localparam int DEPTH    = LANE_LAT + 2;
    localparam logic [LW-1:0] L100 = LW'(log2_fixed(64'(HUNDRED), F));

    logic [CFG_W-1:0] curve_a_reg;
    logic [CFG_W-1:0] offset_b_reg;
    logic [CFG_W-1:0] gain_c_reg;

    logic [DEPTH-1:0] valid_reg;
    logic             en;

    logic [P-1:0]     px_reg [0:2];
    logic [CFG_W-1:0] a_reg;
    logic [CFG_W-1:0] b_reg;
    logic [CFG_W-1:0] c_reg;
    logic [DW-1:0]    nd_reg;
    logic [LW-1:0]    l_den;
    logic [LW-1:0]    ld_reg;
    logic [P-1:0]     y [0:2];
    logic [TW-1:0]    m_tdata_reg;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_a_reg  <= CURVE_A_RST;
            offset_b_reg <= OFFSET_B_RST;
            gain_c_reg   <= GAIN_C_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CURVE_A:  curve_a_reg  <= cfg_wdata;
                REG_OFFSET_B: offset_b_reg <= cfg_wdata;
                REG_GAIN_C:   gain_c_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance the whole pipeline unless the output word is held
    assign en       = !valid_reg[DEPTH-1] || m_tready;
    assign s_tready = en && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // input stage: capture the pixel and a snapshot of the registers
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0] <= s_tdata[P-1:0];
            px_reg[1] <= s_tdata[2*P-1:P];
            px_reg[2] <= s_tdata[3*P-1:2*P];
            a_reg     <= curve_a_reg;
            b_reg     <= offset_b_reg;
            c_reg     <= gain_c_reg;
            nd_reg    <= DW'(curve_a_reg) + DW'(HUNDRED);
        end
    end

    // shared denominator log2(100 + a); one extra register keeps it in step
    // with the lane logs, which start a stage later
    plt_log #(.IW(DW), .F(F)) u_log_den (
        .aclk (aclk),
        .en   (en),
        .n    (nd_reg),
        .l    (l_den)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            ld_reg <= l_den - L100;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        plt_lane #(.P(P), .F(F)) u_lane (
            .aclk (aclk),
            .en   (en),
            .x    (px_reg[g]),
            .a    (a_reg),
            .b    (b_reg),
            .c    (c_reg),
            .ld   (ld_reg),
            .y    (y[g])
        );
    end

    // merge the three lanes into the output word
    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= TW'({y[2], y[1], y[0]});
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = valid_reg[DEPTH-1];

endmodule
`default_nettype wire

>>> hdl/plt_log.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_log: pipelined fixed-point log2
// Normalise in one stage, then one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
module plt_log
    import plt_pkg::*;
#(
    parameter int IW = 23,
    parameter int F  = 16
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [IW-1:0] n,
    output logic [KW+F-1:0]    l
);

    logic [KW-1:0] k_reg [0:F];
    logic [ZW-1:0] z_reg [0:F];
    logic [F-1:0]  f_reg [0:F];

    logic [KW-1:0] k0;
    logic [ZW-1:0] z0;

    // leading-one position and normalised mantissa
    always_comb begin
        k0 = '0;
        for (int i = 0; i < IW; i++) begin
            if (n[i]) begin
                k0 = KW'(i);
            end
        end
        z0 = ZW'(n) << (KW'(LOG_PREC) - k0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg[0] <= k0;
            z_reg[0] <= z0;
            f_reg[0] <= '0;
        end
    end

    for (genvar s = 1; s <= F; s++) begin : g_sq
        logic [2*ZW-1:0] sq;
        logic [ZW:0]     zs;
        logic [ZW-1:0]   z_next;
        logic            bit_next;

        always_comb begin
            sq = {{ZW{1'b0}}, z_reg[s-1]} * {{ZW{1'b0}}, z_reg[s-1]};
            zs = sq[LOG_PREC+ZW:LOG_PREC];
            if (zs[ZW]) begin
                z_next   = zs[ZW:1];
                bit_next = 1'b1;
            end else begin
                z_next   = zs[ZW-1:0];
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                k_reg[s] <= k_reg[s-1];
                z_reg[s] <= z_next;
                f_reg[s] <= {f_reg[s-1][F-2:0], bit_next};
            end
        end
    end

    assign l = {k_reg[F], f_reg[F]};

endmodule
`default_nettype wire

>>> hdl/plt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_div: pipelined quotient of two logs, capped at 2.0
// One restoring step per quotient bit; an overflow check stands in front.
// ----------------------------------------------------------------------------
module plt_div
    import plt_pkg::*;
#(
    parameter int F  = 16,
    parameter int LW = 21
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [LW-1:0] ln,
    input  wire logic [LW-1:0] ld,
    output logic [F+1:0]       q,
    output logic               ld_zero
);

    localparam int QW = F + 2;
    localparam logic [QW-1:0] CAP = QW'(2) << F;

    logic [LW-1:0] r_reg    [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic [QW-1:0] nb_reg   [0:QW];
    logic [LW-1:0] d_reg    [0:QW];
    logic          ovf_reg  [0:QW];
    logic          zero_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= ln >> 2;
            q_reg[0]    <= '0;
            nb_reg[0]   <= {ln[1:0], {F{1'b0}}};
            d_reg[0]    <= ld;
            ovf_reg[0]  <= (ln >> 2) >= ld;
            zero_reg[0] <= (ld == '0);
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_step
        logic [LW:0]   t;
        logic [LW-1:0] r_next;
        logic          bit_next;

        always_comb begin
            t = {r_reg[s-1], nb_reg[s-1][QW-1]};
            if (t >= {1'b0, d_reg[s-1]}) begin
                r_next   = LW'(t - {1'b0, d_reg[s-1]});
                bit_next = 1'b1;
            end else begin
                r_next   = t[LW-1:0];
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s]    <= r_next;
                q_reg[s]    <= {q_reg[s-1][QW-2:0], bit_next};
                nb_reg[s]   <= nb_reg[s-1] << 1;
                d_reg[s]    <= d_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    assign q       = (ovf_reg[QW] || (q_reg[QW] > CAP)) ? CAP : q_reg[QW];
    assign ld_zero = zero_reg[QW];

endmodule
`default_nettype wire

>>> hdl/plt_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_lane: one colour channel of the log transform
// Numerator log, quotient, gain and offset, divide by 100 and saturate.
// ----------------------------------------------------------------------------
module plt_lane
    import plt_pkg::*;
#(
    parameter int P = 8,
    parameter int F = 16
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [P-1:0]     x,
    input  wire logic [CFG_W-1:0] a,
    input  wire logic [CFG_W-1:0] b,
    input  wire logic [CFG_W-1:0] c,
    input  wire logic [KW+F-1:0]  ld,
    output logic [P-1:0]          y
);

    localparam int LW     = KW + F;
    localparam int NW     = CFG_W + P + 1;
    localparam int QW     = F + 2;
    localparam int CQW    = CFG_W + QW;
    localparam int VW     = CFG_W + P + 3;
    localparam int RW     = VW - 6;
    localparam int XW     = CFG_W + P;
    localparam int PW     = 2 * VW - 6;
    localparam int SB_LAT = 2 * F + 6;
    localparam longint unsigned PMAX  = (64'd1 << P) - 64'd1;
    localparam logic [NW-1:0]  BASE   = NW'(64'(HUNDRED) * PMAX);
    localparam logic [LW-1:0]  LBASE  = LW'(log2_fixed(64'(HUNDRED) * PMAX, F));
    localparam logic [RW-1:0]  RECIP  = RW'((64'd1 << VW) / 64'(HUNDRED));
    localparam logic [P-1:0]   YMAX   = P'(PMAX);

    typedef struct packed {
        logic [P-1:0]     x;
        logic [CFG_W-1:0] b;
        logic [CFG_W-1:0] c;
    } side_t;

    side_t            sb_reg [0:SB_LAT-1];
    logic [NW-1:0]    n_reg;
    logic [LW-1:0]    l_num;
    logic [QW-1:0]    q;
    logic             ld_zero;
    logic [CQW-1:0]   cq_reg;
    logic             zero1_reg;
    logic [VW-1:0]    v_next;
    logic [VW-1:0]    v_reg;
    logic [2*VW-7:0]  vr_reg;
    logic [VW-1:0]    vd_reg;
    logic [P-1:0]     y_next;
    logic [P-1:0]     y_reg;

    // carry level, offset and gain along the pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= '{x: x, b: b, c: c};
            for (int i = 1; i < SB_LAT; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end
            n_reg <= BASE + NW'(a) * NW'(x);
        end
    end

    plt_log #(.IW(NW), .F(F)) u_log (
        .aclk (aclk),
        .en   (en),
        .n    (n_reg),
        .l    (l_num)
    );

    plt_div #(.F(F), .LW(LW)) u_div (
        .aclk    (aclk),
        .en      (en),
        .ln      (l_num - LBASE),
        .ld      (ld),
        .q       (q),
        .ld_zero (ld_zero)
    );

    always_comb begin
        logic [CQW+P-1:0]     cqm;
        logic [CFG_W+P-1:0]   cx;
        cqm = {cq_reg, {P{1'b0}}} - (CQW+P)'(cq_reg);
        cx  = XW'(sb_reg[SB_LAT-1].c) * XW'(sb_reg[SB_LAT-1].x);
        if (zero1_reg) begin
            v_next = VW'(cx) + VW'(sb_reg[SB_LAT-1].b);
        end else begin
            v_next = VW'(cqm[CQW+P-1:F]) + VW'(sb_reg[SB_LAT-1].b);
        end
    end

    // divide by 100: reciprocal estimate, one correction step
    always_comb begin
        logic [RW-1:0] qe;
        logic [VW-1:0] rem;
        logic [RW:0]   t;
        qe  = vr_reg[2*VW-7:VW];
        rem = vd_reg - VW'(qe) * VW'(HUNDRED);
        t   = {1'b0, qe} + ((rem >= VW'(HUNDRED)) ? (RW+1)'(1) : '0);
        if (t > (RW+1)'(PMAX)) begin
            y_next = YMAX;
        end else begin
            y_next = t[P-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cq_reg    <= CQW'(sb_reg[SB_LAT-2].c) * CQW'(q);
            zero1_reg <= ld_zero;
            v_reg     <= v_next;
            vr_reg    <= PW'(v_reg) * PW'(RECIP);
            vd_reg    <= v_reg;
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule
`default_nettype wire
